// File: hdl/cmbd_pkg.sv
// ----------------------------------------------------------------------------
// cmbd_pkg
// Shared types, codes and lane helpers of the memory bus decoder.
// ----------------------------------------------------------------------------
package cmbd_pkg;

   localparam int WORD_W            = 32;
   localparam int RAM_WORDS_DEF     = 524288;
   localparam int SCRATCH_WORDS_DEF = 256;
   localparam int RAM_WORD_IDX_W    = 21;   // word index within an 8 MB segment
   localparam int FWD_W             = 19;

   // commands
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // access sizes
   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_HALF = 2'd1;
   localparam logic [1:0] SZ_WORD = 2'd2;
   localparam logic [1:0] SZ_WIDE = 2'd3;

   // result targets
   localparam logic [2:0] TGT_RAM     = 3'd0;
   localparam logic [2:0] TGT_SCRATCH = 3'd1;
   localparam logic [2:0] TGT_BIU     = 3'd2;
   localparam logic [2:0] TGT_BIOS    = 3'd3;
   localparam logic [2:0] TGT_HW      = 3'd4;
   localparam logic [2:0] TGT_NONE    = 3'd5;

   // address map, as address[31:23], address[31:19] and address[31:16]
   localparam logic [8:0]  SEG_RAM_USER   = 9'h000;
   localparam logic [8:0]  SEG_RAM_CACHED = 9'h100;
   localparam logic [8:0]  SEG_RAM_UNCACH = 9'h140;
   localparam logic [12:0] BIOS_USER      = 13'h03F8;
   localparam logic [12:0] BIOS_CACHED    = 13'h13F8;
   localparam logic [12:0] BIOS_UNCACH    = 13'h17F8;
   localparam logic [15:0] IO_USER        = 16'h1F80;
   localparam logic [15:0] IO_CACHED      = 16'h9F80;
   localparam logic [15:0] IO_UNCACH      = 16'hBF80;
   localparam logic [15:0] SCRATCH_LIMIT  = 16'h0400;
   localparam logic [31:0] BIU_ADDR       = 32'hFFFE0130;

   typedef struct packed {
      logic                cmd;
      logic [1:0]          access_size;
      logic [WORD_W-1:0]   address;
      logic [WORD_W-1:0]   write_data;
   } cmbd_req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   read_data;
      logic [2:0]          target;
      logic [FWD_W-1:0]    forward_offset;
   } cmbd_rsp_type;

   typedef struct packed {
      logic [2:0]          target;
      logic                wr;
      logic [1:0]          size;
      logic [1:0]          byte_off;
      logic [FWD_W-1:0]    fwd;
   } cmbd_dec_type;

   function automatic logic [WORD_W-1:0] lane_read(input logic [WORD_W-1:0] word,
                                                   input logic [1:0] off,
                                                   input logic [1:0] size);
      logic [WORD_W-1:0] tmp;
      tmp = '0;
      case (size)
         SZ_BYTE: begin
            tmp = word >> {off, 3'b000};
            tmp = {24'h0, tmp[7:0]};
         end
         SZ_HALF: begin
            tmp = word >> {off[1], 4'b0000};
            tmp = {16'h0, tmp[15:0]};
         end
         default: tmp = word;
      endcase
      return tmp;
   endfunction

   function automatic logic [WORD_W-1:0] lane_write(input logic [WORD_W-1:0] word,
                                                    input logic [1:0] off,
                                                    input logic [1:0] size,
                                                    input logic [WORD_W-1:0] data);
      logic [4:0]        sh;
      logic [WORD_W-1:0] mask;
      logic [WORD_W-1:0] res;
      sh   = '0;
      mask = '0;
      res  = data;
      case (size)
         SZ_BYTE: begin
            sh   = {off, 3'b000};
            mask = 32'h0000_00FF << sh;
            res  = (word & ~mask) | ((data << sh) & mask);
         end
         SZ_HALF: begin
            sh   = {off[1], 4'b0000};
            mask = 32'h0000_FFFF << sh;
            res  = (word & ~mask) | ((data << sh) & mask);
         end
         default: res = data;
      endcase
      return res;
   endfunction

endpackage

// File: hdl/cmbd_sram.sv
// ----------------------------------------------------------------------------
// cmbd_sram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module cmbd_sram
   import cmbd_pkg::*;
#(
   parameter int DEPTH = RAM_WORDS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WORD_W-1:0]        rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cmbd_decode.sv
// ----------------------------------------------------------------------------
// cmbd_decode
// Aligns the address and maps an access to RAM, scratchpad, BIOS, I/O,
// the bus-interface register or nothing.
// ----------------------------------------------------------------------------
module cmbd_decode
   import cmbd_pkg::*;
#(
   parameter int RAM_WORDS     = RAM_WORDS_DEF,
   parameter int SCRATCH_WORDS = SCRATCH_WORDS_DEF
) (
   input  cmbd_req_type                     req,
   input  logic                             iso_en,
   output cmbd_dec_type                     dec,
   output logic [RAM_WORD_IDX_W-1:0]        ram_word,
   output logic [$clog2(SCRATCH_WORDS)-1:0] scr_idx
);

   localparam int SCR_AW = $clog2(SCRATCH_WORDS);

   logic [1:0]  size_n;
   logic [31:0] addr;
   logic [10:0] sv;
   logic        blocked;

   always_comb begin
      size_n = (req.access_size == SZ_WIDE) ? SZ_WORD : req.access_size;
      addr   = req.address;
      if (size_n == SZ_HALF) begin
         addr[0] = 1'b0;
      end else if (size_n == SZ_WORD) begin
         addr[1:0] = 2'b00;
      end

      ram_word = addr[22:2];
      blocked  = (req.cmd == CMD_WRITE) && iso_en &&
                 (addr[31:23] != SEG_RAM_UNCACH) &&
                 ({1'b0, ram_word} < 22'(RAM_WORDS));

      // scratch word index folded into the store, at most three subtracts
      sv = {3'b000, addr[9:2]};
      for (int i = 0; i < 3; i++) begin
         if (sv >= 11'(SCRATCH_WORDS)) begin
            sv = sv - 11'(SCRATCH_WORDS);
         end
      end
      scr_idx = sv[SCR_AW-1:0];

      dec.wr       = req.cmd;
      dec.size     = size_n;
      dec.byte_off = addr[1:0];
      dec.fwd      = '0;
      dec.target   = TGT_NONE;

      if (addr[31:23] inside {SEG_RAM_USER, SEG_RAM_CACHED, SEG_RAM_UNCACH}) begin
         dec.target = blocked ? TGT_NONE : TGT_RAM;
      end else if (addr[31:19] inside {BIOS_USER, BIOS_CACHED, BIOS_UNCACH}) begin
         if (req.cmd == CMD_READ) begin
            dec.target = TGT_BIOS;
            dec.fwd    = addr[18:0];
         end
      end else if (addr[31:16] inside {IO_USER, IO_CACHED, IO_UNCACH}) begin
         if (addr[15:0] < SCRATCH_LIMIT) begin
            dec.target = TGT_SCRATCH;
         end else begin
            dec.target = TGT_HW;
            dec.fwd    = {3'b000, addr[15:0]};
         end
      end else if (size_n == SZ_WORD && addr == BIU_ADDR) begin
         dec.target = TGT_BIU;
      end
   end

endmodule

// File: hdl/console_memory_bus_decoder_top.sv
// ----------------------------------------------------------------------------
// console_memory_bus_decoder_top
// Memory bus decoder: main RAM, scratchpad and bus-interface register.
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low, and its result
// shows on rsp_data for one cycle with rsp_strobe high; busy drops in that
// same cycle, so a new access can be taken as the result shows but not
// before. The reciprocal multiply of the mirror fold runs in the accept
// cycle; then ST_QUOT forms quotient times RAM_WORDS, ST_MOD takes the
// remainder and reads the RAM word, ST_RMW merges and writes it back while
// the result is registered, and the registered result is then presented.
// Every access takes the same time, whatever it hits. The receiver cannot
// stall results. After reset a clearing sweep zeroes all RAM_WORDS words of
// main RAM (524288 by default), one word a cycle, with busy high; csr writes
// are taken at any time, but should be made only while idle.
// ----------------------------------------------------------------------------
module console_memory_bus_decoder_top
   import cmbd_pkg::*;
#(
   parameter int RAM_WORDS     = RAM_WORDS_DEF,
   parameter int SCRATCH_WORDS = SCRATCH_WORDS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  cmbd_req_type req_data,
   output logic         rsp_strobe,
   output cmbd_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_wdata
);

   localparam int RAM_AW = $clog2(RAM_WORDS);
   localparam int SCR_AW = $clog2(SCRATCH_WORDS);
   localparam logic [22:0] RAM_RECIP = 23'((64'd1 << 32) / RAM_WORDS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_QUOT  = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_RMW   = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [RAM_AW-1:0]         clr_cnt_ff, clr_cnt_in;
   logic                      iso_ff, iso_in;
   logic [WORD_W-1:0]         biu_ff, biu_in;
   cmbd_rsp_type              rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   cmbd_dec_type              dec, dec_ff;
   logic [RAM_WORD_IDX_W-1:0] ram_word, word_ff;
   logic [SCR_AW-1:0]         scr_idx, scr_idx_ff;
   logic [WORD_W-1:0]         wdata_ff;
   logic [43:0]               prod, prod_ff;
   logic [11:0]               quot;
   logic [32:0]               mprod;
   logic [20:0]               mprod_ff;
   logic [20:0]               rem, rem_fix;
   logic [RAM_AW-1:0]         ram_idx, ram_idx_ff;

   logic                      accept;
   logic                      ram_we, scr_we;
   logic [RAM_AW-1:0]         ram_waddr;
   logic [WORD_W-1:0]         ram_wdata, scr_wdata;
   logic [WORD_W-1:0]         ram_rdata, scr_rdata;
   logic [WORD_W-1:0]         ones;

   cmbd_decode #(
      .RAM_WORDS     (RAM_WORDS),
      .SCRATCH_WORDS (SCRATCH_WORDS)
   ) u_decode (
      .req      (req_data),
      .iso_en   (iso_ff),
      .dec      (dec),
      .ram_word (ram_word),
      .scr_idx  (scr_idx)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // mirror fold: index = word mod RAM_WORDS, quotient estimate low by at most one
   assign prod    = {23'b0, ram_word} * {21'b0, RAM_RECIP};
   assign quot    = prod_ff[43:32];
   assign mprod   = {21'b0, quot} * 33'(RAM_WORDS);
   assign rem     = word_ff - mprod_ff;
   assign rem_fix = (rem >= 21'(RAM_WORDS)) ? (rem - 21'(RAM_WORDS)) : rem;
   assign ram_idx = rem_fix[RAM_AW-1:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         dec_ff     <= dec;
         word_ff    <= ram_word;
         scr_idx_ff <= scr_idx;
         wdata_ff   <= req_data.write_data;
         prod_ff    <= prod;
      end
      if (state_ff == ST_QUOT) begin
         mprod_ff <= mprod[20:0];
      end
      if (state_ff == ST_MOD) begin
         ram_idx_ff <= ram_idx;
      end
   end

   always_comb begin
      case (dec_ff.size)
         SZ_BYTE: ones = 32'h0000_00FF;
         SZ_HALF: ones = 32'h0000_FFFF;
         default: ones = 32'hFFFF_FFFF;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      iso_in       = (csr_valid && csr_ready) ? csr_wdata : iso_ff;
      biu_in       = biu_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = ram_idx_ff;
      ram_wdata    = lane_write(ram_rdata, dec_ff.byte_off, dec_ff.size, wdata_ff);
      scr_we       = 1'b0;
      scr_wdata    = lane_write(scr_rdata, dec_ff.byte_off, dec_ff.size, wdata_ff);

      case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == RAM_AW'(RAM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_QUOT;
            end
         end
         ST_QUOT: state_in = ST_MOD;
         ST_MOD:  state_in = ST_RMW;
         ST_RMW: begin
            state_in              = ST_IDLE;
            rsp_valid_in          = 1'b1;
            rsp_in.target         = dec_ff.target;
            rsp_in.forward_offset = dec_ff.fwd;
            rsp_in.read_data      = '0;
            case (dec_ff.target)
               TGT_RAM: begin
                  ram_we = dec_ff.wr;
                  if (!dec_ff.wr) begin
                     rsp_in.read_data = lane_read(ram_rdata, dec_ff.byte_off, dec_ff.size);
                  end
               end
               TGT_SCRATCH: begin
                  scr_we = dec_ff.wr;
                  if (!dec_ff.wr) begin
                     rsp_in.read_data = lane_read(scr_rdata, dec_ff.byte_off, dec_ff.size);
                  end
               end
               TGT_BIU: begin
                  if (dec_ff.wr) begin
                     biu_in = wdata_ff;
                  end else begin
                     rsp_in.read_data = biu_ff;
                  end
               end
               TGT_NONE: begin
                  if (!dec_ff.wr) begin
                     rsp_in.read_data = ones;
                  end
               end
               default: rsp_in.read_data = '0;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         iso_ff       <= 1'b0;
         biu_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         iso_ff       <= iso_in;
         biu_ff       <= biu_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   cmbd_sram #(
      .DEPTH (RAM_WORDS)
   ) u_main_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (state_ff == ST_MOD),
      .rd_addr (ram_idx),
      .rd_data (ram_rdata)
   );

   cmbd_sram #(
      .DEPTH (SCRATCH_WORDS)
   ) u_scratch (
      .clock   (clock),
      .wr_en   (scr_we),
      .wr_addr (scr_idx_ff),
      .wr_data (scr_wdata),
      .rd_en   (state_ff == ST_MOD),
      .rd_addr (scr_idx_ff),
      .rd_data (scr_rdata)
   );

   // each accepted beat yields exactly one result
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("result beat missing four cycles after accept");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOD |-> rem_fix < 21'(RAM_WORDS))
      else $error("mirror fold produced out-of-range RAM index");

   a_fwd_only_forwarded: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.forward_offset != '0 |->
         (rsp_data.target == TGT_BIOS || rsp_data.target == TGT_HW))
      else $error("forward offset on a non-forwarded result");

   a_no_access_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |=> !rsp_strobe)
      else $error("result issued during RAM clearing sweep");

endmodule

// File: tb/sv/cmbd_checker.sv
// ----------------------------------------------------------------------------
// cmbd_checker
// Scoreboard for the memory bus decoder: tracks every request and csr beat,
// predicts each result from its own model of RAM, scratchpad and the
// bus-interface register, and compares the results field by field.
// ----------------------------------------------------------------------------
module cmbd_checker
   import cmbd_pkg::*;
#(
   parameter int RAM_WORDS     = RAM_WORDS_DEF,
   parameter int SCRATCH_WORDS = SCRATCH_WORDS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  cmbd_req_type req_data,
   input  logic         rsp_strobe,
   input  cmbd_rsp_type rsp_data,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic         csr_wdata,
   output int           fail_count,
   output int           outstanding,
   output int           accept_count,
   output int           csr_count,
   output int           checked_count
);

   // address map, as address[31:23], address[31:19] and address[31:16]
   localparam logic [8:0]  RAM_KUSEG  = 9'h000;
   localparam logic [8:0]  RAM_KSEG0  = 9'h100;
   localparam logic [8:0]  RAM_KSEG1  = 9'h140;
   localparam logic [12:0] ROM_KUSEG  = 13'h03F8;
   localparam logic [12:0] ROM_KSEG0  = 13'h13F8;
   localparam logic [12:0] ROM_KSEG1  = 13'h17F8;
   localparam logic [15:0] IO_KUSEG   = 16'h1F80;
   localparam logic [15:0] IO_KSEG0   = 16'h9F80;
   localparam logic [15:0] IO_KSEG1   = 16'hBF80;
   localparam logic [15:0] SPAD_END   = 16'h0400;
   localparam logic [31:0] BIU_REG    = 32'hFFFE_0130;

   logic [31:0]  ram_image [int unsigned];      // absent entry reads as zero
   logic [31:0]  spad_image [int unsigned];
   logic [31:0]  biu_value;
   logic         isolate;
   cmbd_rsp_type pending_rsp [$];

   function automatic logic [31:0] lane_extract(input logic [31:0] word,
                                                input logic [1:0] off,
                                                input logic [1:0] sz);
      case (sz)
         SZ_BYTE: return (word >> (8 * off)) & 32'h0000_00FF;
         SZ_HALF: return (word >> (16 * off[1])) & 32'h0000_FFFF;
         default: return word;
      endcase
   endfunction

   function automatic logic [31:0] lane_merge(input logic [31:0] word,
                                              input logic [1:0] off,
                                              input logic [1:0] sz,
                                              input logic [31:0] data);
      int unsigned sh;
      logic [31:0] mask;
      if (sz == SZ_BYTE) begin
         sh   = 8 * off;
         mask = 32'h0000_00FF << sh;
      end else if (sz == SZ_HALF) begin
         sh   = 16 * off[1];
         mask = 32'h0000_FFFF << sh;
      end else begin
         return data;
      end
      return (word & ~mask) | ((data << sh) & mask);
   endfunction

   // carries out one access against the model state and returns its result
   function automatic cmbd_rsp_type decode_access(input cmbd_req_type rq);
      cmbd_rsp_type r;
      logic         wr;
      logic [1:0]   sz;
      logic [31:0]  a;
      logic [31:0]  ones;
      logic [31:0]  word;
      logic [22:0]  off;
      int unsigned  idx;
      r        = '0;
      r.target = TGT_NONE;
      wr       = (rq.cmd == CMD_WRITE);
      sz       = (rq.access_size == SZ_WIDE) ? SZ_WORD : rq.access_size;
      a        = rq.address;
      if (sz == SZ_HALF) a[0] = 1'b0;
      else if (sz == SZ_WORD) a[1:0] = 2'b00;
      ones = (sz == SZ_BYTE) ? 32'h0000_00FF :
             (sz == SZ_HALF) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
      off  = a[22:0];

      if (a[31:23] == RAM_KUSEG || a[31:23] == RAM_KSEG0 || a[31:23] == RAM_KSEG1) begin
         idx = (off >> 2) % RAM_WORDS;
         // isolation only hits the first mirror of the cached/user segments
         if (wr && isolate && a[31:23] != RAM_KSEG1 && off < RAM_WORDS * 4) begin
            r.target = TGT_NONE;
         end else begin
            r.target = TGT_RAM;
            word = ram_image.exists(idx) ? ram_image[idx] : 32'h0;
            if (wr) ram_image[idx] = lane_merge(word, a[1:0], sz, rq.write_data);
            else r.read_data = lane_extract(word, a[1:0], sz);
         end
      end else if (a[31:19] == ROM_KUSEG || a[31:19] == ROM_KSEG0 ||
                   a[31:19] == ROM_KSEG1) begin
         if (!wr) begin
            r.target         = TGT_BIOS;
            r.forward_offset = a[18:0];
         end
      end else if (a[31:16] == IO_KUSEG || a[31:16] == IO_KSEG0 ||
                   a[31:16] == IO_KSEG1) begin
         if (a[15:0] < SPAD_END) begin
            idx      = a[9:2] % SCRATCH_WORDS;
            r.target = TGT_SCRATCH;
            word = spad_image.exists(idx) ? spad_image[idx] : 32'h0;
            if (wr) spad_image[idx] = lane_merge(word, a[1:0], sz, rq.write_data);
            else r.read_data = lane_extract(word, a[1:0], sz);
         end else begin
            r.target         = TGT_HW;
            r.forward_offset = {3'b000, a[15:0]};
         end
      end else if (sz == SZ_WORD && a == BIU_REG) begin
         r.target = TGT_BIU;
         if (wr) biu_value = rq.write_data;
         else r.read_data = biu_value;
      end else if (!wr) begin
         r.read_data = ones;
      end
      return r;
   endfunction

   always @(posedge clock) begin : scoreboard
      cmbd_rsp_type want;
      if (reset) begin
         isolate       = 1'b0;
         biu_value     = '0;
         fail_count    = 0;
         outstanding   = 0;
         accept_count  = 0;
         csr_count     = 0;
         checked_count = 0;
         ram_image.delete();
         spad_image.delete();
         pending_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            isolate   = csr_wdata;
            csr_count = csr_count + 1;
         end
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               $error("result beat with nothing expected: %h", rsp_data);
               fail_count = fail_count + 1;
            end else begin
               want          = pending_rsp.pop_front();
               checked_count = checked_count + 1;
               if (rsp_data.read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h",
                         want.read_data, rsp_data.read_data);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.target !== want.target) begin
                  $error("target: expected %0d, got %0d", want.target, rsp_data.target);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.forward_offset !== want.forward_offset) begin
                  $error("forward_offset: expected %h, got %h",
                         want.forward_offset, rsp_data.forward_offset);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            pending_rsp.push_back(decode_access(req_data));
            accept_count = accept_count + 1;
         end
         outstanding = pending_rsp.size();
      end
   end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the memory bus decoder with directed and random accesses over
// several isolation settings and sender idle rates; the checker alongside
// predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import cmbd_pkg::*;

   localparam int WATCHDOG_LIMIT = 1_600_000;   // covers the RAM clearing sweep

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   cmbd_req_type req_data;
   logic         rsp_strobe;
   cmbd_rsp_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_wdata;

   int fail_count;
   int outstanding;
   int accept_count;
   int csr_count;
   int checked_count;
   int sent_count = 0;
   int idle_cycles = 0;
   bit scratch_written [SCRATCH_WORDS_DEF];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   console_memory_bus_decoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   cmbd_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .accept_count  (accept_count),
      .csr_count     (csr_count),
      .checked_count (checked_count)
   );

   // any accepted beat on any channel counts as progress
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("testbench: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic bit hits_scratch(input logic [31:0] addr);
      return (addr[31:16] == 16'h1F80 || addr[31:16] == 16'h9F80 ||
              addr[31:16] == 16'hBF80) && addr[15:10] == 6'd0;
   endfunction

   // called at a falling edge; returns at the falling edge after the accept
   task automatic issue(input logic cmd, input logic [1:0] size,
                        input logic [31:0] addr, input logic [31:0] data);
      cmbd_req_type rq;
      int           target_count;
      rq.cmd         = cmd;
      rq.access_size = size;
      rq.address     = addr;
      rq.write_data  = data;
      target_count   = accept_count + 1;
      start    <= 1'b1;
      req_data <= rq;
      // only full-word writes make a scratchpad word safe to read back
      if (cmd == CMD_WRITE && (size == SZ_WORD || size == SZ_WIDE) && hits_scratch(addr))
         scratch_written[addr[9:2]] = 1'b1;
      sent_count = sent_count + 1;
      do @(negedge clock); while (accept_count < target_count);
   endtask

   task automatic set_isolation(input logic enable);
      int target_count;
      target_count = csr_count + 1;
      csr_valid <= 1'b1;
      csr_wdata <= enable;
      do @(negedge clock); while (csr_count < target_count);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   function automatic cmbd_req_type random_access();
      cmbd_req_type rq;
      int unsigned  pick;
      logic [15:0]  io_seg;
      rq.cmd         = 1'($urandom_range(0, 1));
      rq.access_size = 2'($urandom_range(0, 3));
      rq.address     = $urandom();
      rq.write_data  = $urandom();
      case ($urandom_range(0, 2))
         0:       io_seg = 16'h1F80;
         1:       io_seg = 16'h9F80;
         default: io_seg = 16'hBF80;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         case ($urandom_range(0, 2))
            0:       rq.address[31:23] = 9'h000;
            1:       rq.address[31:23] = 9'h100;
            default: rq.address[31:23] = 9'h140;
         endcase
         // mostly a small pool of words so that reads find earlier writes
         case ($urandom_range(0, 9))
            0:       rq.address[20:2] = '1;
            1:       ;
            default: rq.address[20:2] = 19'($urandom_range(0, 31));
         endcase
      end else if (pick < 55) begin
         rq.address[31:16] = io_seg;
         rq.address[15:10] = 6'd0;
      end else if (pick < 65) begin
         rq.address[31:16] = io_seg;
         if (rq.address[15:10] == 6'd0) rq.address[15:10] = 6'($urandom_range(1, 63));
      end else if (pick < 75) begin
         case ($urandom_range(0, 2))
            0:       rq.address[31:19] = 13'h03F8;
            1:       rq.address[31:19] = 13'h13F8;
            default: rq.address[31:19] = 13'h17F8;
         endcase
      end else if (pick < 85) begin
         rq.address = {30'(32'hFFFE_0130 >> 2), 2'($urandom_range(0, 3))};
      end
      if (rq.cmd == CMD_READ && hits_scratch(rq.address) &&
          !scratch_written[rq.address[9:2]]) begin
         rq.cmd         = CMD_WRITE;
         rq.access_size = SZ_WORD;
      end
      return rq;
   endfunction

   task automatic run_random(input int count, input int idle_pct);
      cmbd_req_type rq;
      for (int n = 0; n < count; n++) begin
         rq = random_access();
         if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         issue(rq.cmd, rq.access_size, rq.address, rq.write_data);
      end
   endtask

   task automatic run_directed();
      // RAM mirrors, lanes, alignment and the wide size code
      issue(CMD_WRITE, SZ_WORD, 32'h0000_0000, 32'h1122_3344);
      issue(CMD_READ,  SZ_BYTE, 32'h8000_0001, 32'h0);
      issue(CMD_READ,  SZ_HALF, 32'hA020_0002, 32'h0);
      issue(CMD_WRITE, SZ_HALF, 32'h8000_0003, 32'hFFFF_BEEF);
      issue(CMD_READ,  SZ_WORD, 32'h0060_0000, 32'h0);
      issue(CMD_WRITE, SZ_BYTE, 32'hA07F_FFFF, 32'hFFFF_FFAB);
      issue(CMD_READ,  SZ_WORD, 32'h007F_FFFC, 32'h0);
      issue(CMD_WRITE, SZ_WIDE, 32'h0000_0006, 32'hCAFE_F00D);
      issue(CMD_READ,  SZ_WIDE, 32'h0000_0007, 32'h0);
      // scratchpad edges, then hw registers and bios
      issue(CMD_WRITE, SZ_WORD, 32'h1F80_0000, 32'h0000_0000);
      issue(CMD_WRITE, SZ_WORD, 32'hBF80_03FF, 32'hFFFF_FFFF);
      issue(CMD_READ,  SZ_BYTE, 32'h9F80_03FF, 32'h0);
      issue(CMD_READ,  SZ_HALF, 32'h1F80_0001, 32'h0);
      issue(CMD_READ,  SZ_HALF, 32'h9F80_0002, 32'h0);
      issue(CMD_READ,  SZ_BYTE, 32'h1F80_0400, 32'h0);
      issue(CMD_WRITE, SZ_WORD, 32'hBF80_FFFF, 32'h1234_5678);
      issue(CMD_READ,  SZ_BYTE, 32'hBFC7_FFFF, 32'h0);
      issue(CMD_WRITE, SZ_WORD, 32'h1FC0_0000, 32'h5555_AAAA);
      // bus-interface register, narrow accesses to it, unmapped reads
      issue(CMD_WRITE, SZ_WORD, 32'hFFFE_0130, 32'hDEAD_BEEF);
      issue(CMD_READ,  SZ_WIDE, 32'hFFFE_0133, 32'h0);
      issue(CMD_READ,  SZ_BYTE, 32'hFFFE_0130, 32'h0);
      issue(CMD_WRITE, SZ_HALF, 32'hFFFE_0131, 32'hFFFF_FFFF);
      issue(CMD_READ,  SZ_WORD, 32'hFFFF_FFFF, 32'h0);
      issue(CMD_READ,  SZ_HALF, 32'h0080_0001, 32'h0);
   endtask

   task automatic run_isolated_directed();
      issue(CMD_WRITE, SZ_WORD, 32'h0000_0010, 32'hA5A5_A5A5);
      issue(CMD_WRITE, SZ_WORD, 32'h8000_0010, 32'h5A5A_5A5A);
      issue(CMD_WRITE, SZ_WORD, 32'hA000_0010, 32'h0F0F_0F0F);
      issue(CMD_WRITE, SZ_BYTE, 32'h001F_FFFF, 32'h0000_0077);
      issue(CMD_WRITE, SZ_BYTE, 32'h0020_0000, 32'h0000_0099);
      issue(CMD_READ,  SZ_WORD, 32'h0000_0010, 32'h0);
      issue(CMD_WRITE, SZ_WORD, 32'h1F80_0010, 32'h8765_4321);
      issue(CMD_WRITE, SZ_HALF, 32'h1F80_1000, 32'h0000_1111);
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_wdata = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // the first access waits out the RAM clearing sweep; csr beats are not held by it
      set_isolation(1'b0);
      run_directed();
      drain();
      set_isolation(1'b1);
      run_isolated_directed();
      run_random(150, 69);
      drain();
      set_isolation(1'b0);
      run_random(300, 0);
      drain();
      set_isolation(1'b1);
      run_random(200, 10);
      drain();
      set_isolation(1'b0);
      run_random(250, 69);
      drain();
      repeat (8) @(negedge clock);

      $display("run covered %0d accesses in five phases, isolation off/on/off/on/off,",
               sent_count);
      $display("sender idle at 0, 10 and 69 percent; %0d results compared, %0d mismatches",
               checked_count, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
